>>> hdl/rppw_pkg.sv
// Package for the rotated page pixel writer: store size, widths, command and
// register codes, and the structs passed between controller, datapath and CSRs.
// No dependencies.
package rppw_pkg;

   localparam int STORE_BYTES = 2048;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int CALC_W      = 18;
   localparam int COORD_W     = 19;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 10;

   localparam logic [1:0] CMD_DRAW  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_ROTATION       = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FLIP_MODE      = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PANEL_WIDTH    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PANEL_HEIGHT   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_LEFT       = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_RIGHT      = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PAGE_FIRST_ROW = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_PAGE_END_ROW   = 4'd7;

   localparam logic [9:0] RST_PANEL_WIDTH  = 10'd128;
   localparam logic [9:0] RST_PANEL_HEIGHT = 10'd296;
   localparam logic [9:0] RST_BOX_RIGHT    = 10'd128;
   localparam logic [9:0] RST_PAGE_END_ROW = 10'd16;

   typedef struct packed {
      logic [1:0] rotation;
      logic [1:0] flip_mode;
      logic [9:0] panel_width;
      logic [9:0] panel_height;
      logic [8:0] box_left;
      logic [9:0] box_right;
      logic [8:0] page_first_row;
      logic [9:0] page_end_row;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic map_en;
      logic chk_en;
      logic mul_en;
      logic rd_idx;
      logic rdw_en;
      logic rmw_en;
      logic sweep_en;
      logic sweep_zero;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic sweep_last;
   } ctrl_sts_type;

endpackage

>>> hdl/rppw_csr.sv
// Configuration registers of the rotated page pixel writer.
// Depends on rppw_pkg.
module rppw_csr
   import rppw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_ROTATION:       cfg_in.rotation       = csr_wr_data[1:0];
            REG_FLIP_MODE:      cfg_in.flip_mode      = csr_wr_data[1:0];
            REG_PANEL_WIDTH:    cfg_in.panel_width    = csr_wr_data[9:0];
            REG_PANEL_HEIGHT:   cfg_in.panel_height   = csr_wr_data[9:0];
            REG_BOX_LEFT:       cfg_in.box_left       = csr_wr_data[8:0];
            REG_BOX_RIGHT:      cfg_in.box_right      = csr_wr_data[9:0];
            REG_PAGE_FIRST_ROW: cfg_in.page_first_row = csr_wr_data[8:0];
            REG_PAGE_END_ROW:   cfg_in.page_end_row   = csr_wr_data[9:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation       <= 2'd0;
         cfg_ff.flip_mode      <= 2'd0;
         cfg_ff.panel_width    <= RST_PANEL_WIDTH;
         cfg_ff.panel_height   <= RST_PANEL_HEIGHT;
         cfg_ff.box_left       <= 9'd0;
         cfg_ff.box_right      <= RST_BOX_RIGHT;
         cfg_ff.page_first_row <= 9'd0;
         cfg_ff.page_end_row   <= RST_PAGE_END_ROW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/rppw_ctrl.sv
// Controller state machine: sequences draw, read and clear items and the
// power-up clearing sweep, and owns the handshakes. Depends on rppw_pkg.
module rppw_ctrl
   import rppw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [1:0]   req_cmd,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   localparam logic [3:0] ST_INIT = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_MAP  = 4'd2;
   localparam logic [3:0] ST_CHK  = 4'd3;
   localparam logic [3:0] ST_MUL  = 4'd4;
   localparam logic [3:0] ST_RMR  = 4'd5;
   localparam logic [3:0] ST_RMW  = 4'd6;
   localparam logic [3:0] ST_RD   = 4'd7;
   localparam logic [3:0] ST_RDW  = 4'd8;
   localparam logic [3:0] ST_CLR  = 4'd9;
   localparam logic [3:0] ST_DONE = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;
   logic       rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            cmd.sweep_en   = 1'b1;
            cmd.sweep_zero = 1'b1;
            if (sts.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               unique case (req_cmd)
                  CMD_DRAW:  state_in = ST_MAP;
                  CMD_READ:  state_in = ST_RD;
                  CMD_CLEAR: state_in = ST_CLR;
                  CMD_NONE:  state_in = ST_DONE;
               endcase
            end
         end
         ST_MAP: begin
            cmd.map_en = 1'b1;
            state_in   = ST_CHK;
         end
         ST_CHK: begin
            cmd.chk_en = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_RMR;
         end
         ST_RMR: begin
            state_in = ST_RMW;
         end
         ST_RMW: begin
            cmd.rmw_en = 1'b1;
            state_in   = ST_DONE;
         end
         ST_RD: begin
            cmd.rd_idx = 1'b1;
            state_in   = ST_RDW;
         end
         ST_RDW: begin
            cmd.rdw_en = 1'b1;
            state_in   = ST_DONE;
         end
         ST_CLR: begin
            cmd.sweep_en = 1'b1;
            if (sts.sweep_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/rppw_dpath.sv
// Datapath: coordinate mapping, box and page test, address multiply, page
// store with byte read-modify-write and fill sweep, result register.
// Depends on rppw_pkg.
module rppw_dpath
   import rppw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  ctrl_cmd_type       cmd,
   output ctrl_sts_type       sts,
   input  logic signed [15:0] req_pixel_x,
   input  logic signed [15:0] req_pixel_y,
   input  logic               req_pixel_color,
   input  logic [10:0]        req_byte_index,
   input  logic               req_fill_white,
   output logic [7:0]         rsp_read_byte,
   output logic               rsp_pixel_hit,
   output logic [10:0]        rsp_hit_address
);

   logic [7:0]  mem [STORE_BYTES];
   logic [7:0]  mem_rd_ff;
   logic [ADDR_W-1:0] mem_ra;
   logic [ADDR_W-1:0] mem_wa;
   logic [7:0]  mem_wd;
   logic        mem_we;

   logic signed [15:0] x_ff;
   logic signed [15:0] y_ff;
   logic        color_ff;
   logic [10:0] idx_ff;
   logic        fill_ff;

   logic signed [COORD_W-1:0] nx_ff, ny_ff, nx_in, ny_in;
   logic signed [COORD_W-1:0] lx, ly, wm1, hm1, src_x, src_y;
   logic signed [COORD_W-1:0] left_s, right_s, first_s, end_s, rdiff, cdiff;
   logic        land, inv_x, inv_y;

   logic        inbox_ff, inbox_in;
   logic [9:0]  row_off_ff;
   logic [6:0]  col_byte_ff;
   logic [6:0]  row_bytes_ff;
   logic [9:0]  span;
   logic [2:0]  bit_ff;

   logic [CALC_W-1:0] addr_ff, addr_in;
   logic        hit_ff, hit_in;

   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [31:0] idx_wide;
   logic        idx_ok;
   logic [7:0]  mask;
   logic [7:0]  rmw_byte;

   logic [7:0]  res_byte_ff;
   logic        res_hit_ff;
   logic [10:0] res_addr_ff;
   logic [7:0]  out_byte_ff;
   logic        out_hit_ff;
   logic [10:0] out_addr_ff;

   // mapping: each native axis is a logical axis, optionally mirrored once
   assign lx    = COORD_W'(x_ff);
   assign ly    = COORD_W'(y_ff);
   assign wm1   = $signed(COORD_W'(cfg.panel_width)) - $signed(COORD_W'(1));
   assign hm1   = $signed(COORD_W'(cfg.panel_height)) - $signed(COORD_W'(1));
   assign land  = cfg.rotation[0];
   assign src_x = land ? ly : lx;
   assign src_y = land ? lx : ly;
   assign inv_x = (cfg.rotation == 2'd1 || cfg.rotation == 2'd2) ^
                  (land ? cfg.flip_mode[1] : cfg.flip_mode[0]);
   assign inv_y = (cfg.rotation == 2'd2 || cfg.rotation == 2'd3) ^
                  (land ? cfg.flip_mode[0] : cfg.flip_mode[1]);
   assign nx_in = inv_x ? (wm1 - src_x) : src_x;
   assign ny_in = inv_y ? (hm1 - src_y) : src_y;

   assign left_s   = $signed(COORD_W'(cfg.box_left));
   assign right_s  = $signed(COORD_W'(cfg.box_right));
   assign first_s  = $signed(COORD_W'(cfg.page_first_row));
   assign end_s    = $signed(COORD_W'(cfg.page_end_row));
   assign inbox_in = (nx_ff >= left_s) && (nx_ff < right_s) &&
                     (ny_ff >= first_s) && (ny_ff < end_s);
   assign rdiff    = ny_ff - first_s;
   assign cdiff    = nx_ff - left_s;
   assign span     = cfg.box_right - 10'(cfg.box_left);

   assign addr_in = CALC_W'(row_off_ff) * CALC_W'(row_bytes_ff) + CALC_W'(col_byte_ff);
   assign hit_in  = inbox_ff && (addr_in < CALC_W'(STORE_BYTES));

   assign idx_wide = 32'(idx_ff);
   assign idx_ok   = idx_wide < 32'(STORE_BYTES);
   assign mask     = 8'h80 >> bit_ff;
   assign rmw_byte = (mem_rd_ff & ~mask) | (color_ff ? mask : 8'h00);

   assign mem_ra = cmd.rd_idx ? idx_wide[ADDR_W-1:0] : addr_ff[ADDR_W-1:0];

   always_comb begin
      mem_we = 1'b0;
      mem_wa = addr_ff[ADDR_W-1:0];
      mem_wd = rmw_byte;
      if (cmd.sweep_en) begin
         mem_we = 1'b1;
         mem_wa = cnt_ff;
         mem_wd = (!cmd.sweep_zero && fill_ff) ? 8'hFF : 8'h00;
      end else if (cmd.rmw_en && hit_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_rd_ff <= mem[mem_ra];
   end

   assign sts.sweep_last = (cnt_ff == ADDR_W'(STORE_BYTES - 1));

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load) cnt_in = '0;
      else if (cmd.sweep_en) cnt_in = sts.sweep_last ? '0 : cnt_ff + ADDR_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff        <= req_pixel_x;
         y_ff        <= req_pixel_y;
         color_ff    <= req_pixel_color;
         idx_ff      <= req_byte_index;
         fill_ff     <= req_fill_white;
         res_byte_ff <= 8'h00;
         res_hit_ff  <= 1'b0;
         res_addr_ff <= 11'd0;
      end
      if (cmd.map_en) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
      end
      if (cmd.chk_en) begin
         inbox_ff     <= inbox_in;
         row_off_ff   <= rdiff[9:0];
         col_byte_ff  <= cdiff[9:3];
         row_bytes_ff <= span[9:3];
         bit_ff       <= nx_ff[2:0];
      end
      if (cmd.mul_en) begin
         addr_ff <= addr_in;
         hit_ff  <= hit_in;
      end
      if (cmd.rmw_en && hit_ff) begin
         res_hit_ff  <= 1'b1;
         res_addr_ff <= addr_ff[10:0];
      end
      if (cmd.rdw_en) begin
         res_byte_ff <= idx_ok ? mem_rd_ff : 8'h00;
      end
      if (cmd.rsp_load) begin
         out_byte_ff <= res_byte_ff;
         out_hit_ff  <= res_hit_ff;
         out_addr_ff <= res_addr_ff;
      end
   end

   assign rsp_read_byte   = out_byte_ff;
   assign rsp_pixel_hit   = out_hit_ff;
   assign rsp_hit_address = out_addr_ff;

endmodule

>>> hdl/rotated_page_pixel_writer.sv
// Top level of the rotated page pixel writer: CSRs, controller, datapath.
// Depends on rppw_pkg, rppw_csr, rppw_ctrl, rppw_dpath.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  cmd, pixel x/y/color, byte index, fill
//   rsp_      out        rsp_valid/rsp_ready  read byte, pixel hit, hit address
//   csr_      in         csr_wr_en            register index, write data
//
// A draw runs from accept through map, box test, address multiply, store
// read, store write and result load. A read runs store read, byte capture
// and result load. A clear sweeps the store at one byte a cycle. After
// reset the store is zeroed by the same sweep with req_ready low. A stalled
// result beat holds in the output register; the next beat is accepted
// meanwhile and waits in its last step.
module rotated_page_pixel_writer
   import rppw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic signed [15:0]    req_pixel_x,
   input  logic signed [15:0]    req_pixel_y,
   input  logic                  req_pixel_color,
   input  logic [10:0]           req_byte_index,
   input  logic                  req_fill_white,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_read_byte,
   output logic                  rsp_pixel_hit,
   output logic [10:0]           rsp_hit_address,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type      cfg;
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   rppw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   rppw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rppw_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .sts             (sts),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_pixel_color (req_pixel_color),
      .req_byte_index  (req_byte_index),
      .req_fill_white  (req_fill_white),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_pixel_hit   (rsp_pixel_hit),
      .rsp_hit_address (rsp_hit_address)
   );

endmodule

>>> hdl/rppw_checker.sv
// Port-level checker for the rotated page pixel writer, bound to the top.
// Depends on rotated_page_pixel_writer.
module rppw_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [7:0]            rsp_read_byte,
   input logic                  rsp_pixel_hit,
   input logic [10:0]           rsp_hit_address
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_byte) &&
      $stable(rsp_pixel_hit) && $stable(rsp_hit_address))
      else $error("stalled response beat changed");

   a_miss_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pixel_hit |-> rsp_hit_address == 11'd0)
      else $error("hit address set without a hit");

   a_hit_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel_hit |-> rsp_read_byte == 8'd0)
      else $error("read byte set on a draw beat");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after an accepted beat");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("handshake active after reset");

endmodule

bind rotated_page_pixel_writer rppw_checker u_rppw_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for rotated_page_pixel_writer: directed and random draw, read,
// clear beats under several window settings, checked against an in-bench page store.
// Depends on rppw_pkg and the RTL of rotated_page_pixel_writer.
module tb_top;
   import rppw_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASE_ITEMS    = 60;

   typedef struct packed {
      logic [7:0]  read_byte;
      logic        pixel_hit;
      logic [10:0] hit_address;
   } pixel_rsp_type;

   class page_tracker;
      logic [1:0]   rotation;
      logic [1:0]   flip_mode;
      logic [9:0]   panel_width;
      logic [9:0]   panel_height;
      logic [8:0]   box_left;
      logic [9:0]   box_right;
      logic [8:0]   page_first_row;
      logic [9:0]   page_end_row;
      logic [7:0]   store [STORE_BYTES];
      pixel_rsp_type pending [$];
      int           mismatches;

      function new();
         rotation       = '0;
         flip_mode      = '0;
         panel_width    = RST_PANEL_WIDTH;
         panel_height   = RST_PANEL_HEIGHT;
         box_left       = '0;
         box_right      = RST_BOX_RIGHT;
         page_first_row = '0;
         page_end_row   = RST_PAGE_END_ROW;
         foreach (store[i]) store[i] = 8'h00;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            REG_ROTATION:       rotation       = v[1:0];
            REG_FLIP_MODE:      flip_mode      = v[1:0];
            REG_PANEL_WIDTH:    panel_width    = v[9:0];
            REG_PANEL_HEIGHT:   panel_height   = v[9:0];
            REG_BOX_LEFT:       box_left       = v[8:0];
            REG_BOX_RIGHT:      box_right      = v[9:0];
            REG_PAGE_FIRST_ROW: page_first_row = v[8:0];
            REG_PAGE_END_ROW:   page_end_row   = v[9:0];
            default: ;
         endcase
      endfunction

      function void note_item(logic [1:0] cmd, logic signed [15:0] px,
                              logic signed [15:0] py, logic color,
                              logic [10:0] bidx, logic fill);
         pixel_rsp_type r;
         int w, h, nx, ny, addr;
         r = '0;
         case (cmd)
            CMD_DRAW: begin
               w = int'(panel_width);
               h = int'(panel_height);
               case (rotation)
                  2'd0: begin nx = int'(px);         ny = int'(py);         end
                  2'd1: begin nx = w - int'(py) - 1; ny = int'(px);         end
                  2'd2: begin nx = w - 1 - int'(px); ny = h - 1 - int'(py); end
                  default: begin nx = int'(py);      ny = h - 1 - int'(px); end
               endcase
               if (flip_mode[0]) begin
                  if (rotation[0]) ny = h - 1 - ny;
                  else nx = w - 1 - nx;
               end
               if (flip_mode[1]) begin
                  if (rotation[0]) nx = w - 1 - nx;
                  else ny = h - 1 - ny;
               end
               if (nx >= int'(box_left) && nx < int'(box_right) &&
                   ny >= int'(page_first_row) && ny < int'(page_end_row)) begin
                  addr = (ny - int'(page_first_row)) *
                         ((int'(box_right) - int'(box_left)) / 8) +
                         (nx - int'(box_left)) / 8;
                  if (addr < STORE_BYTES) begin
                     store[addr][7 - (nx & 7)] = color;
                     r.pixel_hit   = 1'b1;
                     r.hit_address = addr[10:0];
                  end
               end
            end
            CMD_READ: begin
               if (int'(bidx) < STORE_BYTES) r.read_byte = store[bidx];
            end
            CMD_CLEAR: begin
               foreach (store[i]) store[i] = {8{fill}};
            end
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      function void check_rsp(logic [7:0] rb, logic hit, logic [10:0] ha);
         pixel_rsp_type e;
         if (pending.size() == 0) begin
            $error("result beat with no pending item");
            mismatches++;
            return;
         end
         e = pending.pop_front();
         if (rb !== e.read_byte) begin
            $error("read_byte: expected %0h, actual %0h", e.read_byte, rb);
            mismatches++;
         end
         if (hit !== e.pixel_hit) begin
            $error("pixel_hit: expected %0b, actual %0b", e.pixel_hit, hit);
            mismatches++;
         end
         if (ha !== e.hit_address) begin
            $error("hit_address: expected %0d, actual %0d", e.hit_address, ha);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_cmd;
   logic signed [15:0]    req_pixel_x;
   logic signed [15:0]    req_pixel_y;
   logic                  req_pixel_color;
   logic [10:0]           req_byte_index;
   logic                  req_fill_white;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [7:0]            rsp_read_byte;
   logic                  rsp_pixel_hit;
   logic [10:0]           rsp_hit_address;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   page_tracker tracker;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          quiet_cycles = 0;

   rotated_page_pixel_writer i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_pixel_color (req_pixel_color),
      .req_byte_index  (req_byte_index),
      .req_fill_white  (req_fill_white),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_pixel_hit   (rsp_pixel_hit),
      .rsp_hit_address (rsp_hit_address),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1)
         tracker.check_rsp(rsp_read_byte, rsp_pixel_hit, rsp_hit_address);
      if ((req_valid === 1'b1 && req_ready === 1'b1) ||
          (rsp_valid === 1'b1 && rsp_ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic send_item(logic [1:0] cmd, logic signed [15:0] px,
                            logic signed [15:0] py, logic color,
                            logic [10:0] bidx, logic fill);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_cmd         <= cmd;
      req_pixel_x     <= px;
      req_pixel_y     <= py;
      req_pixel_color <= color;
      req_byte_index  <= bidx;
      req_fill_white  <= fill;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.note_item(cmd, px, py, color, bidx, fill);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending.size() != 0);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_index   <= idx;
      csr_wr_data <= data;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      tracker.set_reg(idx, data);
   endtask

   task automatic load_setting(int k);
      int v [8];
      case (k)
         0: v = '{1, 0, 128, 296, 0, 128, 0, 16};
         1: v = '{2, 1, 200, 100, 8, 64, 40, 60};
         2: v = '{3, 2, 64, 64, 16, 48, 10, 30};
         3: v = '{0, 3, 512, 512, 0, 512, 0, 512};
         4: v = '{1, 3, 1, 1, 0, 8, 0, 1};
         5: v = '{2, 2, 128, 296, 64, 8, 20, 10};
         6: begin
            v[0] = $urandom_range(0, 3);
            v[1] = $urandom_range(0, 3);
            v[2] = $urandom_range(1, 512);
            v[3] = $urandom_range(1, 512);
            v[4] = 8 * $urandom_range(0, 62);
            v[5] = v[4] + 8 * $urandom_range(1, (512 - v[4]) / 8);
            v[6] = $urandom_range(0, 500);
            v[7] = v[6] + $urandom_range(1, 12);
         end
         7: foreach (v[i]) v[i] = $urandom_range(0, 1023);
         default: v = '{3, 1, 512, 512, 504, 512, 511, 512};
      endcase
      wait_idle();
      write_reg(REG_ROTATION,       CSR_DATA_W'(v[0]));
      write_reg(REG_FLIP_MODE,      CSR_DATA_W'(v[1]));
      write_reg(REG_PANEL_WIDTH,    CSR_DATA_W'(v[2]));
      write_reg(REG_PANEL_HEIGHT,   CSR_DATA_W'(v[3]));
      write_reg(REG_BOX_LEFT,       CSR_DATA_W'(v[4]));
      write_reg(REG_BOX_RIGHT,      CSR_DATA_W'(v[5]));
      write_reg(REG_PAGE_FIRST_ROW, CSR_DATA_W'(v[6]));
      write_reg(REG_PAGE_END_ROW,   CSR_DATA_W'(v[7]));
      write_reg(CSR_IDX_W'(REG_PAGE_END_ROW + $urandom_range(1, 8)),
                CSR_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   // Pick a native pixel in or just around the box and page, then undo flip and rotation.
   function automatic void aim_pixel(output logic signed [15:0] lx,
                                     output logic signed [15:0] ly);
      int w, h, xs, ys, nx, ny, ax, ay;
      w  = int'(tracker.panel_width);
      h  = int'(tracker.panel_height);
      xs = int'(tracker.box_right) - int'(tracker.box_left);
      ys = int'(tracker.page_end_row) - int'(tracker.page_first_row);
      if (xs < 1) xs = 8;
      if (ys < 1) ys = 4;
      nx = int'(tracker.box_left) - 2 + int'($urandom_range(0, xs + 3));
      ny = int'(tracker.page_first_row) - 2 + int'($urandom_range(0, ys + 3));
      if (tracker.flip_mode[0]) begin
         if (tracker.rotation[0]) ny = h - 1 - ny;
         else nx = w - 1 - nx;
      end
      if (tracker.flip_mode[1]) begin
         if (tracker.rotation[0]) nx = w - 1 - nx;
         else ny = h - 1 - ny;
      end
      case (tracker.rotation)
         2'd0: begin ax = nx;         ay = ny;         end
         2'd1: begin ax = ny;         ay = w - 1 - nx; end
         2'd2: begin ax = w - 1 - nx; ay = h - 1 - ny; end
         default: begin ax = h - 1 - ny; ay = nx;      end
      endcase
      lx = 16'(ax);
      ly = 16'(ay);
   endfunction

   task automatic random_item();
      int                 r;
      logic signed [15:0] lx, ly;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         aim_pixel(lx, ly);
         send_item(CMD_DRAW, lx, ly, 1'($urandom), 11'($urandom), 1'($urandom));
      end else if (r < 65) begin
         send_item(CMD_DRAW, 16'($urandom), 16'($urandom), 1'($urandom),
                   11'($urandom), 1'($urandom));
      end else if (r < 93) begin
         send_item(CMD_READ, 16'($urandom), 16'($urandom), 1'($urandom),
                   $urandom_range(0, 1) ? 11'($urandom_range(0, 255)) : 11'($urandom),
                   1'($urandom));
      end else if (r < 96) begin
         send_item(CMD_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom),
                   11'($urandom), 1'($urandom));
      end else begin
         send_item(CMD_NONE, 16'($urandom), 16'($urandom), 1'($urandom),
                   11'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      tracker         = new();
      send_idle_pct   = 18;
      recv_idle_pct   = 80;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_cmd         <= CMD_NONE;
      req_pixel_x     <= '0;
      req_pixel_y     <= '0;
      req_pixel_color <= 1'b0;
      req_byte_index  <= '0;
      req_fill_white  <= 1'b0;
      csr_wr_en       <= 1'b0;
      csr_index       <= '0;
      csr_wr_data     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // default window: 128 columns, page rows 0 to 15
      send_item(CMD_DRAW, 16'sd0, 16'sd0, 1'b1, 11'd0, 1'b0);
      send_item(CMD_DRAW, 16'sd127, 16'sd15, 1'b1, 11'd0, 1'b0);
      send_item(CMD_DRAW, 16'sd7, 16'sd0, 1'b1, 11'd0, 1'b0);
      send_item(CMD_READ, 16'sd0, 16'sd0, 1'b0, 11'd0, 1'b0);
      send_item(CMD_READ, 16'sd0, 16'sd0, 1'b0, 11'd255, 1'b0);
      send_item(CMD_DRAW, 16'sd128, 16'sd0, 1'b1, 11'd0, 1'b0);
      send_item(CMD_DRAW, 16'sd0, 16'sd16, 1'b1, 11'd0, 1'b0);
      send_item(CMD_DRAW, -16'sd1, 16'sd0, 1'b1, 11'd0, 1'b0);
      send_item(CMD_DRAW, -16'sd32768, -16'sd32768, 1'b1, 11'd0, 1'b0);
      send_item(CMD_DRAW, 16'sd32767, 16'sd32767, 1'b0, 11'd2047, 1'b1);
      send_item(CMD_DRAW, 16'sd0, 16'sd0, 1'b0, 11'd0, 1'b0);
      send_item(CMD_READ, 16'sd0, 16'sd0, 1'b0, 11'd0, 1'b0);
      send_item(CMD_READ, 16'sd0, 16'sd0, 1'b0, 11'd2047, 1'b0);
      send_item(CMD_NONE, -16'sd1, -16'sd1, 1'b1, 11'd2047, 1'b1);
      send_item(CMD_CLEAR, 16'sd0, 16'sd0, 1'b0, 11'd0, 1'b1);
      send_item(CMD_READ, 16'sd0, 16'sd0, 1'b0, 11'd1024, 1'b0);
      send_item(CMD_DRAW, 16'sd9, 16'sd3, 1'b0, 11'd0, 1'b0);
      send_item(CMD_READ, 16'sd0, 16'sd0, 1'b0, 11'd49, 1'b0);
      send_item(CMD_READ, 16'sd0, 16'sd0, 1'b0, 11'd2047, 1'b0);
      send_item(CMD_CLEAR, 16'sd0, 16'sd0, 1'b1, 11'd0, 1'b0);
      send_item(CMD_READ, 16'sd0, 16'sd0, 1'b0, 11'd49, 1'b0);

      for (int k = 0; k < 9; k++) begin
         if (k < 3) begin
            send_idle_pct = 18;
            recv_idle_pct = 80;
         end else if (k < 6) begin
            send_idle_pct = 80;
            recv_idle_pct = 18;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         load_setting(k);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off until the pipe is empty once per phase
            if (n == PHASE_ITEMS / 2) wait_idle();
            random_item();
         end
      end

      wait_idle();
      repeat (32) @(posedge clock);
      if (tracker.mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

>>> rotated_page_pixel_writer.f
hdl/rppw_pkg.sv
hdl/rppw_csr.sv
hdl/rppw_ctrl.sv
hdl/rppw_dpath.sv
hdl/rotated_page_pixel_writer.sv
hdl/rppw_checker.sv
tb/tb_top.sv
